/* sv/assert_macros.svh */
// Assertion macros shared by the RTL.
// Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* sv/slru_pkg.sv */
`default_nettype none

package slru_pkg;

  // List geometry and key width
  localparam int PROTECTED_DEPTH = 8;
  localparam int PROBATION_DEPTH = 8;
  localparam int KEY_BITS        = 32;

  // Configuration port
  localparam int LIMIT_BITS    = 4;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = LIMIT_BITS;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(8);

  // Counts hold 0..depth, a pre-trim count holds 0..depth+1
  localparam int P_CNT_W = $clog2(PROTECTED_DEPTH + 1);
  localparam int B_CNT_W = $clog2(PROBATION_DEPTH + 1);
  localparam int P_N_W   = $clog2(PROTECTED_DEPTH + 2);
  localparam int B_N_W   = $clog2(PROBATION_DEPTH + 2);
  localparam int P_IDX_W = (PROTECTED_DEPTH > 1) ? $clog2(PROTECTED_DEPTH) : 1;
  localparam int B_IDX_W = (PROBATION_DEPTH > 1) ? $clog2(PROBATION_DEPTH) : 1;

  // Common width for count against limit compares
  localparam int CMP_A = (P_N_W > B_N_W) ? P_N_W : B_N_W;
  localparam int CMP_W = (CMP_A > LIMIT_BITS) ? CMP_A : LIMIT_BITS;

  // Dump walk index over both lists
  localparam int DUMP_W = $clog2(PROTECTED_DEPTH + PROBATION_DEPTH + 1);

  // Register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_PROTECTED_LIMIT = 1'b0,
    REG_PROBATION_LIMIT = 1'b1
  } cfg_reg_t;

  // Input opcodes
  typedef enum logic {
    OP_ACCESS = 1'b0,
    OP_DUMP   = 1'b1
  } op_t;

  // Result kinds
  typedef enum logic {
    KIND_ACCESS = 1'b0,
    KIND_DUMP   = 1'b1
  } kind_t;

  // Lookup outcome
  typedef enum logic [1:0] {
    LS_MISS      = 2'd0,
    LS_PROB_HIT  = 2'd1,
    LS_PROT_HIT  = 2'd2
  } lookup_status_t;

  // Dump entry list
  typedef enum logic {
    SEG_PROTECTED = 1'b0,
    SEG_PROBATION = 1'b1
  } segment_t;

  // Per-cell move: keep, take from the head side, take from the tail side
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LEFT  = 2'd1,
    CELL_RIGHT = 2'd2
  } cell_op_t;

endpackage

`default_nettype wire

/* sv/slru_if.sv */
`default_nettype none

// Input channel: one word per access or dump request
interface slru_item_if import slru_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                op;
  logic [KEY_BITS-1:0] key;

  modport source (output valid, output op, output key, input ready);
  modport sink   (input valid, input op, input key, output ready);
endinterface

// Output channel: access reports and dump entries
interface slru_result_if import slru_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                result_kind;
  logic [1:0]          lookup_status;
  logic                demoted_valid;
  logic                dropped_valid;
  logic [KEY_BITS-1:0] dropped_key;
  logic                entry_valid;
  logic                entry_segment;
  logic [KEY_BITS-1:0] entry_key;
  logic                last;

  modport source (
    output valid, output result_kind, output lookup_status, output demoted_valid,
    output dropped_valid, output dropped_key, output entry_valid, output entry_segment,
    output entry_key, output last, input ready
  );
  modport sink (
    input valid, input result_kind, input lookup_status, input demoted_valid,
    input dropped_valid, input dropped_key, input entry_valid, input entry_segment,
    input entry_key, input last, output ready
  );
endinterface

`default_nettype wire

/* sv/slru_cell.sv */
`default_nettype none

// One list slot: holds a key, compares it, and moves along the row.
module slru_cell import slru_pkg::*; (
  input  wire logic                clk,
  input  wire cell_op_t            op,
  input  wire logic [KEY_BITS-1:0] left_key,
  input  wire logic [KEY_BITS-1:0] right_key,
  input  wire logic [KEY_BITS-1:0] cmp_key,
  input  wire logic                occupied,
  output      logic [KEY_BITS-1:0] key,
  output      logic                hit
);

  // key slot
  always_ff @(posedge clk) begin
    unique case (op)
      CELL_LEFT:  key <= left_key;
      CELL_RIGHT: key <= right_key;
      default:    key <= key;
    endcase
  end

  // match only counts inside the live part of the list
  assign hit = occupied && (key == cmp_key);

endmodule

`default_nettype wire

/* sv/segmented_lru_tracker.sv */
// Channel  Dir  Handshake     Word
// item     in   valid/ready   op, key
// result   out  valid/ready   access report or one dump entry
// cfg      in   cfg_we        cfg_index, cfg_data (limits)
//
// Access: the LOOKUP state registers the parallel compare in every cell, then
//   the UPDATE state shifts the cell rows and writes the result register.
// Dump: one result per cycle while the result register is free, protected row then probation row, walked by a counter.
// Reset (rst, synchronous) empties both lists and sets both limits to 8.
// A full result register stalls the shift cycle; the lists change only when the
// report can be written.
`default_nettype none
`include "assert_macros.svh"

module segmented_lru_tracker import slru_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
  slru_item_if.sink                     item,
  slru_result_if.source                 result
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE,
    ST_DUMP
  } state_t;

  state_t                state;
  state_t                start_state;
  logic [LIMIT_BITS-1:0] plimit;
  logic [LIMIT_BITS-1:0] blimit;
  logic [P_CNT_W-1:0]    pcount;
  logic [B_CNT_W-1:0]    bcount;
  logic [KEY_BITS-1:0]   key_q;
  logic [DUMP_W-1:0]     dump_idx;

  // compare results, registered and live, and slot occupancy
  logic [PROTECTED_DEPTH-1:0] p_hit;
  logic [PROBATION_DEPTH-1:0] b_hit;
  logic [PROTECTED_DEPTH-1:0] p_hit_now;
  logic [PROBATION_DEPTH-1:0] b_hit_now;
  logic [PROTECTED_DEPTH-1:0] p_occ;
  logic [PROBATION_DEPTH-1:0] b_occ;

  // cell rows
  logic [KEY_BITS-1:0] p_key [PROTECTED_DEPTH];
  logic [KEY_BITS-1:0] b_key [PROBATION_DEPTH];
  cell_op_t            p_op  [PROTECTED_DEPTH];
  cell_op_t            b_op  [PROBATION_DEPTH];
  logic [KEY_BITS-1:0] b_head;

  // result register
  logic                out_valid;
  logic                out_kind;
  logic [1:0]          out_status;
  logic                out_demoted;
  logic                out_dropped;
  logic [KEY_BITS-1:0] out_dropped_key;
  logic                out_entry_valid;
  logic                out_segment;
  logic [KEY_BITS-1:0] out_entry_key;
  logic                out_last;

  // handshake
  logic out_free;
  logic commit;
  logic dump_emit;
  logic accept;

  // update datapath
  logic                p_any;
  logic                b_any;
  logic                p_ins;
  logic                b_ins;
  logic                b_rem;
  logic                b_miss;
  logic [PROTECTED_DEPTH-1:0] p_left;
  logic [PROBATION_DEPTH-1:0] b_left;
  logic [PROBATION_DEPTH-1:0] b_right;
  logic [KEY_BITS-1:0] p_ext [PROTECTED_DEPTH+1];
  logic [KEY_BITS-1:0] b_ext [PROBATION_DEPTH+1];
  logic [P_N_W-1:0]    p_n;
  logic [B_N_W-1:0]    b_n;
  logic                demote;
  logic                drop;
  logic [KEY_BITS-1:0] d_key;
  logic [KEY_BITS-1:0] drop_key;
  logic [P_CNT_W-1:0]  pcount_next;
  logic [B_CNT_W-1:0]  bcount_next;
  logic [1:0]          status;

  // dump walk
  logic [DUMP_W-1:0]   total;
  logic [DUMP_W-1:0]   b_off;
  logic                in_prot;
  logic                dump_last;
  logic [KEY_BITS-1:0] dump_key;

  // protected row
  for (genvar i = 0; i < PROTECTED_DEPTH; i++) begin : g_prot
    logic [KEY_BITS-1:0] left_in;
    logic [KEY_BITS-1:0] right_in;
    if (i == 0) begin : g_head
      assign left_in = key_q;
    end else begin : g_body
      assign left_in = p_key[i-1];
    end
    if (i == PROTECTED_DEPTH - 1) begin : g_tail
      assign right_in = p_key[i];
    end else begin : g_inner
      assign right_in = p_key[i+1];
    end
    assign p_occ[i] = P_CNT_W'(i) < pcount;
    slru_cell u_cell (
      .clk       (clk),
      .op        (p_op[i]),
      .left_key  (left_in),
      .right_key (right_in),
      .cmp_key   (key_q),
      .occupied  (p_occ[i]),
      .key       (p_key[i]),
      .hit       (p_hit_now[i])
    );
  end

  // probation row
  for (genvar i = 0; i < PROBATION_DEPTH; i++) begin : g_prob
    logic [KEY_BITS-1:0] left_in;
    logic [KEY_BITS-1:0] right_in;
    if (i == 0) begin : g_head
      assign left_in = b_head;
    end else begin : g_body
      assign left_in = b_key[i-1];
    end
    if (i == PROBATION_DEPTH - 1) begin : g_tail
      assign right_in = b_key[i];
    end else begin : g_inner
      assign right_in = b_key[i+1];
    end
    assign b_occ[i] = B_CNT_W'(i) < bcount;
    slru_cell u_cell (
      .clk       (clk),
      .op        (b_op[i]),
      .left_key  (left_in),
      .right_key (right_in),
      .cmp_key   (key_q),
      .occupied  (b_occ[i]),
      .key       (b_key[i]),
      .hit       (b_hit_now[i])
    );
  end

  // handshake
  assign out_free  = !out_valid || result.ready;
  assign commit    = (state == ST_UPDATE) && out_free;
  assign dump_emit = (state == ST_DUMP) && out_free;
  assign item.ready = (state == ST_IDLE) || commit || (dump_emit && dump_last);
  assign accept    = item.valid && item.ready;
  assign start_state = (op_t'(item.op) == OP_DUMP) ? ST_DUMP : ST_LOOKUP;

  // shift plan for both rows from the registered hits
  always_comb begin
    logic acc;
    logic [PROTECTED_DEPTH-1:0] p_ge;
    logic [PROBATION_DEPTH-1:0] b_ge;
    logic [PROBATION_DEPTH-1:0] b_le;

    p_any  = |p_hit;
    b_any  = |b_hit;
    p_ins  = p_any || b_any;
    b_miss = !p_any && !b_any;

    // cells at or ahead of the hit, and for probation also at or behind it
    acc = 1'b0;
    for (int i = PROTECTED_DEPTH - 1; i >= 0; i--) begin
      acc     = acc | p_hit[i];
      p_ge[i] = acc;
    end
    acc = 1'b0;
    for (int i = PROBATION_DEPTH - 1; i >= 0; i--) begin
      acc     = acc | b_hit[i];
      b_ge[i] = acc;
    end
    acc = 1'b0;
    for (int i = 0; i < PROBATION_DEPTH; i++) begin
      acc     = acc | b_hit[i];
      b_le[i] = acc;
    end

    // protected: push at head, a hit closes the gap at its slot
    for (int i = 0; i < PROTECTED_DEPTH; i++) begin
      p_left[i] = p_ins && (!p_any || p_ge[i]);
    end
    p_ext[0] = key_q;
    for (int i = 1; i < PROTECTED_DEPTH; i++) begin
      p_ext[i] = p_left[i] ? p_key[i-1] : p_key[i];
    end
    p_ext[PROTECTED_DEPTH] = p_key[PROTECTED_DEPTH-1];

    p_n = P_N_W'(pcount);
    if (p_ins && !p_any) begin
      p_n = p_n + P_N_W'(1);
    end
    demote = p_ins && ((CMP_W'(p_n) > CMP_W'(plimit)) ||
                       (p_n == P_N_W'(PROTECTED_DEPTH + 1)));
    d_key  = p_ext[P_CNT_W'(p_n - P_N_W'(1))];
    if (!p_ins) begin
      pcount_next = pcount;
    end else if (demote) begin
      pcount_next = P_CNT_W'(p_n - P_N_W'(1));
    end else begin
      pcount_next = P_CNT_W'(p_n);
    end

    // probation: miss or demoted key enters at head, a promoted key leaves
    b_ins  = b_miss || demote;
    b_rem  = b_any && !demote;
    b_head = b_miss ? key_q : d_key;
    for (int i = 0; i < PROBATION_DEPTH; i++) begin
      b_left[i]  = b_ins && (!b_any || b_ge[i]);
      b_right[i] = b_rem && b_le[i];
    end
    b_ext[0] = b_head;
    for (int i = 1; i < PROBATION_DEPTH; i++) begin
      b_ext[i] = b_left[i] ? b_key[i-1] : b_key[i];
    end
    b_ext[PROBATION_DEPTH] = b_key[PROBATION_DEPTH-1];

    b_n = B_N_W'(bcount);
    if (b_ins && !b_any) begin
      b_n = b_n + B_N_W'(1);
    end else if (b_rem) begin
      b_n = b_n - B_N_W'(1);
    end
    drop = b_ins && ((CMP_W'(b_n) > CMP_W'(blimit)) ||
                     (b_n == B_N_W'(PROBATION_DEPTH + 1)));
    drop_key = b_ext[B_CNT_W'(b_n - B_N_W'(1))];
    if (drop) begin
      bcount_next = B_CNT_W'(b_n - B_N_W'(1));
    end else begin
      bcount_next = B_CNT_W'(b_n);
    end

    if (p_any) begin
      status = LS_PROT_HIT;
    end else if (b_any) begin
      status = LS_PROB_HIT;
    end else begin
      status = LS_MISS;
    end

    // row moves only on the commit cycle
    for (int i = 0; i < PROTECTED_DEPTH; i++) begin
      p_op[i] = (commit && p_left[i]) ? CELL_LEFT : CELL_HOLD;
    end
    for (int i = 0; i < PROBATION_DEPTH; i++) begin
      if (commit && b_left[i]) begin
        b_op[i] = CELL_LEFT;
      end else if (commit && b_right[i]) begin
        b_op[i] = CELL_RIGHT;
      end else begin
        b_op[i] = CELL_HOLD;
      end
    end
  end

  // dump entry select
  always_comb begin
    total     = DUMP_W'(pcount) + DUMP_W'(bcount);
    in_prot   = dump_idx < DUMP_W'(pcount);
    b_off     = dump_idx - DUMP_W'(pcount);
    dump_last = (total == '0) || (dump_idx + DUMP_W'(1) == total);
    dump_key  = in_prot ? p_key[dump_idx[P_IDX_W-1:0]] : b_key[b_off[B_IDX_W-1:0]];
  end

  // sequencer, limits, counts and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      pcount    <= '0;
      bcount    <= '0;
      plimit    <= LIMIT_RESET;
      blimit    <= LIMIT_RESET;
      dump_idx  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_PROTECTED_LIMIT: plimit <= cfg_data;
          REG_PROBATION_LIMIT: blimit <= cfg_data;
        endcase
      end

      // word taken and no new one loaded behind it
      if (out_valid && result.ready && !commit && !dump_emit) begin
        out_valid <= 1'b0;
      end

      // key of a new word
      if (accept) begin
        key_q <= item.key;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= start_state;
          end
        end
        ST_LOOKUP: begin
          p_hit <= p_hit_now;
          b_hit <= b_hit_now;
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (commit) begin
            pcount          <= pcount_next;
            bcount          <= bcount_next;
            out_valid       <= 1'b1;
            out_kind        <= KIND_ACCESS;
            out_status      <= status;
            out_demoted     <= demote;
            out_dropped     <= drop;
            out_dropped_key <= drop ? drop_key : '0;
            out_entry_valid <= 1'b0;
            out_segment     <= SEG_PROTECTED;
            out_entry_key   <= '0;
            out_last        <= 1'b1;
            state           <= accept ? start_state : ST_IDLE;
          end
        end
        ST_DUMP: begin
          if (dump_emit) begin
            out_valid       <= 1'b1;
            out_kind        <= KIND_DUMP;
            out_status      <= LS_MISS;
            out_demoted     <= 1'b0;
            out_dropped     <= 1'b0;
            out_dropped_key <= '0;
            out_entry_valid <= (total != '0);
            out_segment     <= ((total != '0) && !in_prot) ? SEG_PROBATION : SEG_PROTECTED;
            out_entry_key   <= (total != '0) ? dump_key : '0;
            out_last        <= dump_last;
            // walk index is back at zero for the next dump
            if (dump_last) begin
              dump_idx <= '0;
              state    <= accept ? start_state : ST_IDLE;
            end else begin
              dump_idx <= dump_idx + DUMP_W'(1);
            end
          end
        end
      endcase
    end
  end

  assign result.valid         = out_valid;
  assign result.result_kind   = out_kind;
  assign result.lookup_status = out_status;
  assign result.demoted_valid = out_demoted;
  assign result.dropped_valid = out_dropped;
  assign result.dropped_key   = out_dropped_key;
  assign result.entry_valid   = out_entry_valid;
  assign result.entry_segment = out_segment;
  assign result.entry_key     = out_entry_key;
  assign result.last          = out_last;

  // a key lives in at most one slot of both rows
  `ASSERT_IMPLY(a_hit_unique, clk, rst, state == ST_UPDATE, $onehot0({p_hit, b_hit}))
  // counts never pass the row length
  `ASSERT_IMPLY(a_count_range, clk, rst, 1'b1, (pcount <= P_CNT_W'(PROTECTED_DEPTH)) && (bcount <= B_CNT_W'(PROBATION_DEPTH)))
  // a stalled update leaves the lists untouched
  `ASSERT_NEXT(a_stall_holds, clk, rst, (state == ST_UPDATE) && !out_free, (state == ST_UPDATE) && $stable(pcount) && $stable(bcount))
  // a commit always loads the result register
  `ASSERT_NEXT(a_commit_loads, clk, rst, commit, out_valid && !out_kind)

endmodule

`default_nettype wire
